// ===== src/depth_pixel_backprojection_defines.svh =====
// ----------------------------------------------------------------------------
// Depth pixel back-projection assertion macros
// Shared concurrent assertion forms for the block's checker.
// ----------------------------------------------------------------------------
`ifndef DEPTH_PIXEL_BACKPROJECTION_DEFINES_SVH
`define DEPTH_PIXEL_BACKPROJECTION_DEFINES_SVH

// Implication checked at every clock edge outside reset
`define DPB_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("depth_pixel_backprojection check failed");

// Plain invariant, built on the implication form
`define DPB_ASSERT_ALWAYS(label, expr) \
  `DPB_ASSERT_IMPL(label, 1'b1, expr)

`endif

// ===== src/dpb_pkg.sv =====
// ----------------------------------------------------------------------------
// Depth pixel back-projection package
// Widths, register codes, reset values and the configuration struct.
// ----------------------------------------------------------------------------
package dpb_pkg;

  // Field widths
  localparam int DEPTH_W     = 16;
  localparam int CENTER_W    = 13;
  localparam int INV_W       = 24;
  localparam int COORD_WIDTH = 12;
  localparam int OUT_W       = 34;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 24;

  // Datapath widths
  localparam int TWICE_W    = COORD_WIDTH + 1;
  localparam int MAG_W      = (CENTER_W > TWICE_W) ? CENTER_W : TWICE_W;
  localparam int DM_W       = DEPTH_W + MAG_W;
  localparam int PROD_W     = DM_W + INV_W;
  localparam int FRAC_SHIFT = 21;
  localparam int Q_W        = PROD_W + 1 - FRAC_SHIFT;
  localparam int SAT_W      = (Q_W > OUT_W) ? Q_W : OUT_W;

  // Rounding constant and saturation limits
  localparam logic [PROD_W:0]    ROUND_HALF = (PROD_W + 1)'(1) << (FRAC_SHIFT - 1);
  localparam logic [SAT_W-1:0]   LIM_NEG    = SAT_W'(1) << (OUT_W - 1);
  localparam logic [SAT_W-1:0]   LIM_POS    = LIM_NEG - SAT_W'(1);

  // Pipeline stages from item accept to result strobe
  localparam int PIPE_DEPTH = 5;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_INV_FX   = 2'd2,
    REG_INV_FY   = 2'd3
  } dpb_reg_t;

  // Camera configuration
  typedef struct packed {
    logic [CENTER_W-1:0] center_x_half;
    logic [CENTER_W-1:0] center_y_half;
    logic [INV_W-1:0]    inv_focal_x;
    logic [INV_W-1:0]    inv_focal_y;
  } dpb_cfg_t;

  localparam dpb_cfg_t CFG_RESET = '{
    center_x_half: CENTER_W'(639),
    center_y_half: CENTER_W'(479),
    inv_focal_x:   INV_W'(31957),
    inv_focal_y:   INV_W'(31957)
  };

endpackage

// ===== src/dpb_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Configuration registers
// Principal point and reciprocal focal lengths, written one at a time.
// ----------------------------------------------------------------------------
module dpb_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [dpb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dpb_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output dpb_pkg::dpb_cfg_t             cfg
);
  import dpb_pkg::*;

  dpb_cfg_t cfg_r;
  dpb_cfg_t cfg_nxt;

  // Decode the write; unknown indexes leave everything alone
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_CENTER_X: cfg_nxt.center_x_half = cfg_wdata[CENTER_W-1:0];
        REG_CENTER_Y: cfg_nxt.center_y_half = cfg_wdata[CENTER_W-1:0];
        REG_INV_FX:   cfg_nxt.inv_focal_x   = cfg_wdata[INV_W-1:0];
        REG_INV_FY:   cfg_nxt.inv_focal_y   = cfg_wdata[INV_W-1:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== src/dpb_axis.sv =====
// ----------------------------------------------------------------------------
// Single-axis projection pipeline
// depth*(center - 2*pos)*inv / 2^21, rounded half away, saturated; 5 stages.
// ----------------------------------------------------------------------------
module dpb_axis (
  input  logic                             clk,
  input  logic [dpb_pkg::DEPTH_W-1:0]      depth,
  input  logic [dpb_pkg::COORD_WIDTH-1:0]  pos,
  input  logic [dpb_pkg::CENTER_W-1:0]     center,
  input  logic [dpb_pkg::INV_W-1:0]        inv,
  output logic signed [dpb_pkg::OUT_W-1:0] coord
);
  import dpb_pkg::*;

  logic [TWICE_W-1:0] twice;
  logic [MAG_W-1:0]   center_ext;
  logic [MAG_W-1:0]   twice_ext;
  logic               neg_nxt;
  logic [MAG_W-1:0]   mag_nxt;
  logic [DM_W-1:0]    dm_nxt;
  logic [PROD_W-1:0]  prod_nxt;
  logic [PROD_W:0]    sum;
  logic [Q_W-1:0]     q_nxt;
  logic [SAT_W-1:0]   q_ext;
  logic [SAT_W-1:0]   q_sat;
  logic [OUT_W-1:0]   mag_out;
  logic [OUT_W-1:0]   coord_nxt;

  logic [DEPTH_W-1:0] depth_r;
  logic [MAG_W-1:0]   mag_r;
  logic [DM_W-1:0]    dm_r;
  logic [PROD_W-1:0]  prod_r;
  logic [Q_W-1:0]     q_r;
  logic [OUT_W-1:0]   coord_r;
  logic               neg1_r;
  logic               neg2_r;
  logic               neg3_r;
  logic               neg4_r;

  // Stage 1: signed offset from the principal point, as sign and magnitude
  always_comb begin
    twice      = {pos, 1'b0};
    center_ext = MAG_W'(center);
    twice_ext  = MAG_W'(twice);
    neg_nxt    = twice_ext > center_ext;
    mag_nxt    = neg_nxt ? (twice_ext - center_ext) : (center_ext - twice_ext);
  end

  // Stage 2: depth times offset
  assign dm_nxt = DM_W'(depth_r) * DM_W'(mag_r);

  // Stage 3: times the reciprocal focal length
  assign prod_nxt = PROD_W'(dm_r) * PROD_W'(inv);

  // Stage 4: round to nearest, ties away from zero (magnitude form)
  assign sum   = {1'b0, prod_r} + ROUND_HALF;
  assign q_nxt = sum[PROD_W:FRAC_SHIFT];

  // Stage 5: saturate, then apply the sign
  always_comb begin
    q_ext = SAT_W'(q_r);
    if (neg4_r) begin
      q_sat = (q_ext > LIM_NEG) ? LIM_NEG : q_ext;
    end else begin
      q_sat = (q_ext > LIM_POS) ? LIM_POS : q_ext;
    end
    mag_out   = q_sat[OUT_W-1:0];
    coord_nxt = neg4_r ? (OUT_W'(0) - mag_out) : mag_out;
  end

  always_ff @(posedge clk) begin
    depth_r <= depth;
    mag_r   <= mag_nxt;
    neg1_r  <= neg_nxt;
    dm_r    <= dm_nxt;
    neg2_r  <= neg1_r;
    prod_r  <= prod_nxt;
    neg3_r  <= neg2_r;
    q_r     <= q_nxt;
    neg4_r  <= neg3_r;
    coord_r <= coord_nxt;
  end

  assign coord = signed'(coord_r);

endmodule

// ===== src/depth_pixel_backprojection.sv =====
// ----------------------------------------------------------------------------
// Depth pixel back-projection
// Pipeline: 5 stages from item accept to result strobe.
// Throughput: one item per cycle; busy is low whenever out of reset.
// Each axis runs offset, a 16x13-bit and a 29x24-bit multiply, rounding and saturation.
// Reset: synchronous active-low; clears config to defaults and drops items in flight.
// ----------------------------------------------------------------------------
module depth_pixel_backprojection (
  input  logic                              clk,
  input  logic                              rst_n,
  // Item input
  input  logic                              start,
  output logic                              busy,
  input  logic [dpb_pkg::DEPTH_W-1:0]       in_depth_mm,
  input  logic [dpb_pkg::COORD_WIDTH-1:0]   in_column,
  input  logic [dpb_pkg::COORD_WIDTH-1:0]   in_row,
  // Result output
  output logic                              out_strobe,
  output logic                              out_point_valid,
  output logic [dpb_pkg::DEPTH_W-1:0]       out_forward_mm,
  output logic signed [dpb_pkg::OUT_W-1:0]  out_lateral_sixteenth_mm,
  output logic signed [dpb_pkg::OUT_W-1:0]  out_vertical_sixteenth_mm,
  // Configuration
  input  logic                              cfg_we,
  input  logic [dpb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dpb_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import dpb_pkg::*;

  dpb_cfg_t           cfg;
  logic               accept;
  logic               busy_r;
  logic [PIPE_DEPTH-1:0] valid_r;
  logic [PIPE_DEPTH-1:0] valid_nxt;
  logic [DEPTH_W-1:0] depth_pipe_r [PIPE_DEPTH];

  assign accept = start && !busy_r;

  dpb_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  dpb_axis u_lateral (
    .clk    (clk),
    .depth  (in_depth_mm),
    .pos    (in_column),
    .center (cfg.center_x_half),
    .inv    (cfg.inv_focal_x),
    .coord  (out_lateral_sixteenth_mm)
  );

  dpb_axis u_vertical (
    .clk    (clk),
    .depth  (in_depth_mm),
    .pos    (in_row),
    .center (cfg.center_y_half),
    .inv    (cfg.inv_focal_y),
    .coord  (out_vertical_sixteenth_mm)
  );

  // Valid bits ride alongside the axis stages
  assign valid_nxt = {valid_r[PIPE_DEPTH-2:0], accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b1;
      valid_r <= '0;
    end else begin
      busy_r  <= 1'b0;
      valid_r <= valid_nxt;
    end
  end

  // Depth delay line matching the axis latency
  always_ff @(posedge clk) begin
    depth_pipe_r[0] <= in_depth_mm;
    for (int i = 1; i < PIPE_DEPTH; i++) begin
      depth_pipe_r[i] <= depth_pipe_r[i-1];
    end
  end

  // Zero depth yields zero products, so only the flag needs decoding
  assign busy            = busy_r;
  assign out_strobe      = valid_r[PIPE_DEPTH-1];
  assign out_forward_mm  = depth_pipe_r[PIPE_DEPTH-1];
  assign out_point_valid = depth_pipe_r[PIPE_DEPTH-1] != '0;

endmodule

// ===== src/dpb_checker.sv =====
// ----------------------------------------------------------------------------
// Depth pixel back-projection checker
// Port-level timing and zero-depth checks, bound to the top level.
// ----------------------------------------------------------------------------
`include "depth_pixel_backprojection_defines.svh"

module dpb_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic [dpb_pkg::DEPTH_W-1:0]       in_depth_mm,
  input logic                              out_strobe,
  input logic                              out_point_valid,
  input logic [dpb_pkg::DEPTH_W-1:0]       out_forward_mm,
  input logic signed [dpb_pkg::OUT_W-1:0]  out_lateral_sixteenth_mm,
  input logic signed [dpb_pkg::OUT_W-1:0]  out_vertical_sixteenth_mm
);
  import dpb_pkg::*;

  // Every accepted item strobes out after the fixed latency
  `DPB_ASSERT_IMPL(a_item_out, start && !busy, ##5 out_strobe)

  // No result without an item accepted the same latency earlier
  `DPB_ASSERT_IMPL(a_no_phantom, out_strobe, $past(start && !busy, 5))

  // Forward distance is the depth of the item that caused it
  `DPB_ASSERT_IMPL(a_forward, out_strobe, out_forward_mm == $past(in_depth_mm, 5))

  // A point without depth carries all-zero coordinates
  `DPB_ASSERT_ALWAYS(a_zero_depth, !out_strobe || out_point_valid ||
    (out_forward_mm == '0 && out_lateral_sixteenth_mm == '0 &&
     out_vertical_sixteenth_mm == '0))

endmodule

bind depth_pixel_backprojection dpb_checker u_dpb_checker (.*);

// ===== tb/tb_depth_pixel_backprojection.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Depth pixel back-projection testbench
// Sends depth pixels through the item input port and checks every result point
// against a built-in pinhole back-projection predictor. Directed tests cover
// reset settings, zero depth, rounding ties and register extremes; random
// phases vary camera settings and drive bursty traffic.
// ----------------------------------------------------------------------------
module tb_depth_pixel_backprojection;
  import dpb_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 250;
  localparam int PHASES      = 6;

  // One back-projected point
  typedef struct {
    logic                    valid;
    logic [DEPTH_W-1:0]      forward;
    logic signed [OUT_W-1:0] lateral;
    logic signed [OUT_W-1:0] vertical;
  } point_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [DEPTH_W-1:0] in_depth_mm = '0;
  logic [COORD_WIDTH-1:0] in_column = '0;
  logic [COORD_WIDTH-1:0] in_row = '0;
  logic out_strobe;
  logic out_point_valid;
  logic [DEPTH_W-1:0] out_forward_mm;
  logic signed [OUT_W-1:0] out_lateral_sixteenth_mm;
  logic signed [OUT_W-1:0] out_vertical_sixteenth_mm;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  dpb_cfg_t camera = CFG_RESET;
  point_t pending_points[$];
  int failures = 0;
  int cycle_count = 0;

  depth_pixel_backprojection dut (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .start                     (start),
    .busy                      (busy),
    .in_depth_mm               (in_depth_mm),
    .in_column                 (in_column),
    .in_row                    (in_row),
    .out_strobe                (out_strobe),
    .out_point_valid           (out_point_valid),
    .out_forward_mm            (out_forward_mm),
    .out_lateral_sixteenth_mm  (out_lateral_sixteenth_mm),
    .out_vertical_sixteenth_mm (out_vertical_sixteenth_mm),
    .cfg_we                    (cfg_we),
    .cfg_index                 (cfg_index),
    .cfg_wdata                 (cfg_wdata)
  );

  // Clock
  initial begin
    forever #1 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // depth * (center - 2*pos) * inv / 2^21, rounded half away from zero, saturated
  function automatic logic signed [OUT_W-1:0] scaled_offset(
    input logic [DEPTH_W-1:0]     depth,
    input logic [CENTER_W-1:0]    center,
    input logic [COORD_WIDTH-1:0] pos,
    input logic [INV_W-1:0]       inv
  );
    logic [63:0] twice;
    logic [63:0] mag;
    logic [63:0] prod;
    logic [63:0] q;
    logic        neg;
    twice = 64'(pos) << 1;
    neg   = twice > 64'(center);
    mag   = neg ? (twice - 64'(center)) : (64'(center) - twice);
    prod  = 64'(depth) * mag * 64'(inv);
    q     = (prod + (64'd1 << (FRAC_SHIFT - 1))) >> FRAC_SHIFT;
    if (neg) begin
      if (q > (64'd1 << (OUT_W - 1)))
        q = 64'd1 << (OUT_W - 1);
      q = 64'd0 - q;
    end else if (q > ((64'd1 << (OUT_W - 1)) - 64'd1)) begin
      q = (64'd1 << (OUT_W - 1)) - 64'd1;
    end
    return q[OUT_W-1:0];
  endfunction

  // Expected point for one pixel under the current camera settings
  function automatic point_t backproject_pixel(
    input logic [DEPTH_W-1:0]     depth,
    input logic [COORD_WIDTH-1:0] col,
    input logic [COORD_WIDTH-1:0] row
  );
    point_t p;
    p.valid    = 1'b0;
    p.forward  = '0;
    p.lateral  = '0;
    p.vertical = '0;
    if (depth != '0) begin
      p.valid    = 1'b1;
      p.forward  = depth;
      p.lateral  = scaled_offset(depth, camera.center_x_half, col, camera.inv_focal_x);
      p.vertical = scaled_offset(depth, camera.center_y_half, row, camera.inv_focal_y);
    end
    return p;
  endfunction

  // Result checker: every strobe must match the oldest pending point
  always @(posedge clk) begin
    point_t exp_p;
    if (rst_n && out_strobe === 1'b1) begin
      if (pending_points.size() == 0) begin
        $error("result strobe with no pending item");
        failures++;
      end else begin
        exp_p = pending_points.pop_front();
        if (out_point_valid !== exp_p.valid) begin
          $error("point_valid expected %0d got %0d", exp_p.valid, out_point_valid);
          failures++;
        end
        if (out_forward_mm !== exp_p.forward) begin
          $error("forward_mm expected %0d got %0d", exp_p.forward, out_forward_mm);
          failures++;
        end
        if (out_lateral_sixteenth_mm !== exp_p.lateral) begin
          $error("lateral_sixteenth_mm expected %0d got %0d",
                 exp_p.lateral, out_lateral_sixteenth_mm);
          failures++;
        end
        if (out_vertical_sixteenth_mm !== exp_p.vertical) begin
          $error("vertical_sixteenth_mm expected %0d got %0d",
                 exp_p.vertical, out_vertical_sixteenth_mm);
          failures++;
        end
      end
    end
  end

  // Present one pixel and hold it until accepted; start stays high afterwards
  task automatic send_pixel(input logic [DEPTH_W-1:0] depth,
                            input logic [COORD_WIDTH-1:0] col,
                            input logic [COORD_WIDTH-1:0] row);
    start       <= 1'b1;
    in_depth_mm <= depth;
    in_column   <= col;
    in_row      <= row;
    do @(posedge clk); while (busy !== 1'b0);
    pending_points.insert(pending_points.size(), backproject_pixel(depth, col, row));
  endtask

  // Drop start for a number of cycles
  task automatic idle_cycles(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Stop sending and wait until every pending point has come out
  task automatic drain_points();
    start <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (2 * PIPE_DEPTH) @(posedge clk);
  endtask

  // Write all four camera registers while the block is idle
  task automatic set_camera(input logic [CFG_DATA_W-1:0] cx, input logic [CFG_DATA_W-1:0] cy,
                            input logic [CFG_DATA_W-1:0] ix, input logic [CFG_DATA_W-1:0] iy);
    logic [CFG_DATA_W-1:0] vals[4];
    dpb_reg_t              idx;
    vals[0] = cx;
    vals[1] = cy;
    vals[2] = ix;
    vals[3] = iy;
    drain_points();
    for (int i = 0; i < 4; i++) begin
      idx = dpb_reg_t'(i);
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_wdata <= vals[i];
      @(posedge clk);
      case (idx)
        REG_CENTER_X: camera.center_x_half = vals[i][CENTER_W-1:0];
        REG_CENTER_Y: camera.center_y_half = vals[i][CENTER_W-1:0];
        REG_INV_FX:   camera.inv_focal_x   = vals[i][INV_W-1:0];
        REG_INV_FY:   camera.inv_focal_y   = vals[i][INV_W-1:0];
        default: ;
      endcase
    end
    cfg_we <= 1'b0;
  endtask

  // Pixels under the reset camera settings
  task automatic test_reset_settings();
    send_pixel(16'd1000, 12'd319, 12'd239);
    send_pixel(16'hFFFF, 12'd0, 12'd0);
    send_pixel(16'hFFFF, 12'hFFF, 12'hFFF);
    send_pixel(16'd1, 12'd320, 12'd240);
    send_pixel(16'd500, 12'd100, 12'd400);
  endtask

  // No measurement: invalid point with zero coordinates
  task automatic test_zero_depth();
    send_pixel(16'd0, 12'd0, 12'd0);
    send_pixel(16'd0, 12'hFFF, 12'hFFF);
    send_pixel(16'd0, 12'($urandom), 12'($urandom));
  endtask

  // Exact half results round away from zero on both signs
  task automatic test_rounding_ties();
    set_camera(24'd1, 24'd1, 24'h100000, 24'h100000);
    send_pixel(16'd1, 12'd0, 12'd0);
    send_pixel(16'd1, 12'd1, 12'd1);
    send_pixel(16'd3, 12'd0, 12'd1);
    send_pixel(16'd3, 12'd1, 12'd0);
  endtask

  // Register extremes, zero reciprocal and masking of wide center writes
  task automatic test_register_extremes();
    set_camera(24'd0, 24'hFFFFFF, 24'hFFFFFF, 24'd0);
    send_pixel(16'hFFFF, 12'hFFF, 12'd0);
    send_pixel(16'hFFFF, 12'd0, 12'hFFF);
    send_pixel(16'd1, 12'hFFF, 12'hFFF);
    set_camera(24'h001FFF, 24'hFFE000, 24'd0, 24'hFFFFFF);
    send_pixel(16'hFFFF, 12'd0, 12'hFFF);
    send_pixel(16'hFFFF, 12'hFFF, 12'd0);
  endtask

  // Random camera settings per phase with bursty pixel traffic
  task automatic test_random_traffic();
    logic [CFG_DATA_W-1:0] vals[4];
    logic [DEPTH_W-1:0]     depth;
    logic [COORD_WIDTH-1:0] col;
    logic [COORD_WIDTH-1:0] row;
    int                     burst_left;
    int                     gap;
    for (int phase = 0; phase < PHASES; phase++) begin
      for (int i = 0; i < 4; i++) begin
        case ($urandom_range(0, 3))
          0: vals[i] = '0;
          1: vals[i] = '1;
          2: vals[i] = CFG_DATA_W'($urandom);
          default: vals[i] = (i < 2) ? CFG_DATA_W'($urandom_range(0, 8191))
                                     : CFG_DATA_W'($urandom_range(1, 200000));
        endcase
      end
      // first phase keeps the reset focal lengths for realistic magnitudes
      if (phase == 0) begin
        vals[2] = CFG_RESET.inv_focal_x;
        vals[3] = CFG_RESET.inv_focal_y;
      end
      set_camera(vals[0], vals[1], vals[2], vals[3]);
      burst_left = $urandom_range(1, 24);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        case ($urandom_range(0, 15))
          0: depth = '0;
          1: depth = '1;
          2: depth = 16'd1;
          default: depth = DEPTH_W'($urandom);
        endcase
        col = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? '1 : '0)
                                          : COORD_WIDTH'($urandom);
        row = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? '1 : '0)
                                          : COORD_WIDTH'($urandom);
        send_pixel(depth, col, row);
        // hold off mid-phase until the pipeline is empty
        if (phase == 2 && k == PHASE_ITEMS / 2) begin
          drain_points();
        end else if (phase != 0) begin
          burst_left--;
          if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                              : $urandom_range(0, 4);
            idle_cycles(gap);
            burst_left = $urandom_range(1, 24);
          end
        end
      end
    end
  endtask

  // Main sequence
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_settings();
    test_zero_depth();
    test_rounding_ties();
    test_register_extremes();
    test_random_traffic();
    drain_points();
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/dpb_pkg.sv
src/dpb_cfg_regs.sv
src/dpb_axis.sv
src/depth_pixel_backprojection.sv
src/dpb_checker.sv
tb/tb_depth_pixel_backprojection.sv
